FILE: sv/xs64_pkg.sv
// Shared types, constants and controller codes for the xorshift64* random source.
package xs64_pkg;

  // Generator constants
  localparam logic [63:0] SEED_RESET = 64'd88172645463325252;
  localparam logic [63:0] DRAW_MULT  = 64'h2545_f491_4f6c_dd1d;
  localparam int unsigned SHIFT_A    = 12;
  localparam int unsigned SHIFT_B    = 25;
  localparam int unsigned SHIFT_C    = 27;
  localparam logic [7:0]  BYTE_MASK  = 8'hff;

  // Sequencing
  localparam int unsigned MUL_STEPS = 3;
  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  // Request codes (code 3 is unused)
  typedef enum logic [1:0] {
    REQ_RAW     = 2'd0,
    REQ_BOOL    = 2'd1,
    REQ_UNIFORM = 2'd2
  } req_kind_t;

  // Transaction payloads
  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  probability_per_byte;
    logic [63:0] bound;
  } req_t;

  typedef struct packed {
    logic [63:0] value;
    logic        error;
  } rsp_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADVANCE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic       load_req;
    logic       advance;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       div_en;
    logic       div_first;
    logic       out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] req_type;
    logic       bound_zero;
    logic       out_free;
  } status_t;

endpackage

FILE: sv/xs64_ctrl.sv
// Controller state machine sequencing advance, multiply, reduction and output load.
module xs64_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  xs64_pkg::status_t status,
  output xs64_pkg::cmd_t    cmd
);
  import xs64_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt;
  logic             mul_last, div_last;

  assign mul_last = (cnt == CNT_W'(MUL_STEPS - 1));
  assign div_last = (cnt == CNT_W'(DIV_STEPS - 1));

  // State and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state_next != state) begin
        cnt <= '0;
      end else if (state == ST_MUL || state == ST_DIV) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_ADVANCE;
      end
      ST_ADVANCE: begin
        if (status.req_type == REQ_RAW || status.req_type == REQ_BOOL ||
            status.req_type == REQ_UNIFORM) begin
          state_next = ST_MUL;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_MUL: begin
        if (mul_last) begin
          if (status.req_type == REQ_UNIFORM && !status.bound_zero) begin
            state_next = ST_DIV;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_DIV: begin
        if (div_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall     = 1'b0;
        cmd.load_req = in_valid;
      end
      ST_ADVANCE: begin
        cmd.advance = (status.req_type == REQ_RAW || status.req_type == REQ_BOOL ||
                       status.req_type == REQ_UNIFORM);
      end
      ST_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = cnt[1:0];
      end
      ST_DIV: begin
        cmd.div_en    = 1'b1;
        cmd.div_first = (cnt == '0);
      end
      ST_DONE: begin
        cmd.out_load = status.out_free;
      end
      default: ;
    endcase
  end

endmodule

FILE: sv/xs64_dpath.sv
// Datapath: generator state, shared 32x32 multiplier, restoring remainder unit, output register.
module xs64_dpath (
  input  logic              clk,
  input  logic              rst,
  input  xs64_pkg::req_t    in_data,
  input  logic              cfg_wr_en,
  input  logic [63:0]       cfg_wr_data,
  input  xs64_pkg::cmd_t    cmd,
  output xs64_pkg::status_t status,
  output logic              out_valid,
  input  logic              out_stall,
  output xs64_pkg::rsp_t    out_data
);
  import xs64_pkg::*;

  req_t        req;
  logic [63:0] gen_state;
  logic [63:0] acc;
  logic [63:0] rem;
  logic [63:0] dvd;

  logic [63:0] xs_a, xs_b, xs_next;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [63:0] div_src, div_rem_in;
  logic [64:0] trial;
  logic [64:0] trial_sub;
  rsp_t        rsp_next;

  // Xorshift step
  always_comb begin
    xs_a    = gen_state ^ (gen_state >> SHIFT_A);
    xs_b    = xs_a ^ (xs_a << SHIFT_B);
    xs_next = xs_b ^ (xs_b >> SHIFT_C);
  end

  // Partial product select: lo*lo, lo*hi, hi*lo (the hi*hi term falls off the top)
  always_comb begin
    unique case (cmd.mul_sel)
      2'd0:    begin mul_a = gen_state[31:0];  mul_b = DRAW_MULT[31:0];  end
      2'd1:    begin mul_a = gen_state[31:0];  mul_b = DRAW_MULT[63:32]; end
      default: begin mul_a = gen_state[63:32]; mul_b = DRAW_MULT[31:0];  end
    endcase
    prod = {32'd0, mul_a} * {32'd0, mul_b};
  end

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    div_src    = cmd.div_first ? acc : dvd;
    div_rem_in = cmd.div_first ? 64'd0 : rem;
    trial      = {div_rem_in, div_src[63]};
    trial_sub  = trial - {1'b0, req.bound};
  end

  // Result select
  always_comb begin
    rsp_next = '0;
    unique case (req.req_type)
      REQ_RAW:  rsp_next.value = acc;
      REQ_BOOL: rsp_next.value = {63'd0, ((acc[7:0] & BYTE_MASK) < req.probability_per_byte)};
      REQ_UNIFORM: begin
        if (req.bound == '0) begin
          rsp_next.error = 1'b1;
        end else begin
          rsp_next.value = rem;
        end
      end
      default: rsp_next = '0;
    endcase
  end

  // Generator state: reset value, seed write or advance
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state <= SEED_RESET;
    end else if (cfg_wr_en) begin
      gen_state <= cfg_wr_data;
    end else if (cmd.advance) begin
      gen_state <= xs_next;
    end
  end

  // Request capture, multiply accumulate and remainder registers
  always_ff @(posedge clk) begin
    if (cmd.load_req) req <= in_data;
    if (cmd.mul_en) begin
      if (cmd.mul_sel == 2'd0) begin
        acc <= prod;
      end else begin
        acc <= acc + {prod[31:0], 32'd0};
      end
    end
    if (cmd.div_en) begin
      dvd <= {div_src[62:0], 1'b0};
      rem <= trial_sub[64] ? trial[63:0] : trial_sub[63:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_data <= rsp_next;
  end

  assign status.req_type   = req.req_type;
  assign status.bound_zero = (req.bound == '0);
  assign status.out_free   = !out_valid || !out_stall;

endmodule

FILE: sv/xorshift64star_random_source.sv
// xorshift64* random source: 64-bit generator with raw, biased-bool and uniform requests.
//
// Request channel in_valid / in_stall / in_data carries req_type, probability_per_byte and
// bound; a transaction is taken when in_valid is high and in_stall low. Result channel
// out_valid / out_stall / out_data carries value and error, one result per request.
// cfg_wr_en with cfg_wr_data reloads the generator state (the seed); the user must
// write it only while idle; the block does not enforce this. Each request runs: accept,
// xorshift advance, 64x64 multiply as three 32x32 partial products on one shared
// multiplier, then for uniform requests with a nonzero bound a restoring remainder,
// one bit per cycle, and an output load; an unused request code returns a zero result.
// One request is in flight at a time; the remainder loop sets the uniform rate.
// The result sits in an output register, so the next request is accepted while a result
// waits. If the receiver stalls, a finished request waits in its final step until the
// register frees and the block takes nothing new meanwhile.
// Synchronous reset loads the state with the default seed and empties the output.
module xorshift64star_random_source (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  xs64_pkg::req_t   in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output xs64_pkg::rsp_t   out_data,
  input  logic             cfg_wr_en,
  input  logic [63:0]      cfg_wr_data
);
  import xs64_pkg::*;

  cmd_t    cmd;
  status_t status;

  xs64_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  xs64_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

`ifndef SYNTHESIS
  // An accepted transaction makes the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted but block not busy");

  // The output register is only loaded when its slot is free
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result overwritten while stalled");

  // An error result always carries a zero value
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.error) |-> (out_data.value == 64'd0))
    else $error("error result with nonzero value");
`endif

endmodule
